### hdl/rx_fragment_chain_assembler_assert.svh
// Assertion macros used by the assembler control module.
`ifndef RX_FRAGMENT_CHAIN_ASSEMBLER_ASSERT_SVH
`define RX_FRAGMENT_CHAIN_ASSEMBLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RFCA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked outside reset.
`define RFCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### hdl/rfca_pkg.sv
`default_nettype none

package rfca_pkg;

  localparam int MAX_PENDING_DEF = 6;

  localparam int CTL_W   = 32;
  localparam int BUF_W   = 16;
  localparam int LEN_W   = 14;
  localparam int TOT_W   = 16;
  localparam int FLAG_W  = 8;
  localparam int CHAIN_W = 17;

  localparam logic [1:0] KIND_WRITE    = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_RELEASE  = 2'd2;

  localparam logic [CTL_W-1:0]  KEEP_MASK  = 32'hfffe_0007;
  localparam logic [FLAG_W-1:0] FLAG_FINAL = 8'h02;
  localparam logic [FLAG_W-1:0] FLAGS_MASK = 8'hfe;

  localparam int SHIFT_TOTAL   = 3;
  localparam int SHIFT_COUNT   = 5;
  localparam int SHIFT_ORDINAL = 2;

  typedef struct packed {
    logic [CTL_W-1:0] control_word;
    logic [BUF_W-1:0] buf_id;
    logic [LEN_W-1:0] frag_len;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        action_kind;
    logic [BUF_W-1:0]  target_buf;
    logic [CTL_W-1:0]  control_out;
    logic [TOT_W-1:0]  packet_total;
    logic [LEN_W-1:0]  piece_len;
    logic [FLAG_W-1:0] dispatch_flags;
    logic              run_last;
  } out_item_t;

  typedef struct packed {
    logic [BUF_W-1:0] buf_id;
    logic [LEN_W-1:0] frag_len;
  } slot_t;

endpackage

`default_nettype wire

### hdl/rfca_slot_mem.sv
`default_nettype none

module rfca_slot_mem
  import rfca_pkg::*;
#(
  parameter int DEPTH = MAX_PENDING_DEF + 1
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire slot_t                    wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output slot_t                         rd_data
);

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/rfca_ctrl.sv
`default_nettype none

`include "rx_fragment_chain_assembler_assert.svh"

module rfca_ctrl
  import rfca_pkg::*;
#(
  parameter int MAX_PENDING = MAX_PENDING_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire in_item_t                            in_data,
  input  wire logic                                out_free,
  output logic                                     act_valid,
  output out_item_t                                act,
  output logic                                     wr_en,
  output logic [$clog2(MAX_PENDING + 1)-1:0]       wr_addr,
  output slot_t                                    wr_data,
  output logic                                     rd_en,
  output logic [$clog2(MAX_PENDING + 1)-1:0]       rd_addr,
  input  wire slot_t                               rd_data
);

  localparam int SLOTS = MAX_PENDING + 1;
  localparam int AW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_WRITE_OWN = 6'b000010,
    S_DISP_OWN  = 6'b000100,
    S_REL_OWN   = 6'b001000,
    S_SLOT_HEAD = 6'b010000,
    S_SLOTS     = 6'b100000
  } state_t;

  state_t             state, state_next;
  logic               chain_open, chain_open_next;
  logic               dropping, dropping_next;
  logic [CTL_W-1:0]   head_control, head_control_next;
  logic [CHAIN_W-1:0] chain_length, chain_length_next;
  logic [CW-1:0]      stored_count, stored_count_next;

  in_item_t           rec;
  logic               standalone;
  logic               run_release;
  logic [CW-1:0]      run_cnt;
  logic [TOT_W-1:0]   run_total;
  logic [CTL_W-1:0]   run_ctl;
  logic [AW-1:0]      idx;

  logic               in_fire;
  logic               act_fire;
  logic               more;
  logic               chain_path;
  logic               opening;
  logic               closing;
  logic               overflow;
  logic               store;
  logic [CW-1:0]      base_cnt;
  logic [CW-1:0]      cnt_new;
  logic [CHAIN_W-1:0] len_sum;
  logic [CTL_W-1:0]   head_sel;
  logic [CW-1:0]      ord;
  logic               last_slot;
  logic [FLAG_W-1:0]  slot_flags;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign act_fire   = act_valid && out_free;

  assign more       = in_data.control_word[0];
  assign chain_path = !dropping && (chain_open || more);
  assign opening    = chain_path && !chain_open;
  assign closing    = chain_path && !more;
  assign base_cnt   = opening ? '0 : stored_count;
  assign store      = base_cnt < CW'(SLOTS);
  assign cnt_new    = base_cnt + CW'(store);
  assign overflow   = chain_path && more && (cnt_new > CW'(MAX_PENDING));
  assign len_sum    = (opening ? '0 : chain_length) + CHAIN_W'(in_data.frag_len);
  assign head_sel   = opening ? in_data.control_word : head_control;

  assign ord        = CW'(idx) + CW'(1);
  assign last_slot  = (ord == run_cnt);
  assign slot_flags = ((FLAG_W'(run_cnt) << SHIFT_COUNT)
                      | (FLAG_W'(ord) << SHIFT_ORDINAL)
                      | (last_slot ? FLAG_FINAL : '0)) & FLAGS_MASK;

  always_comb begin
    state_next        = state;
    chain_open_next   = chain_open;
    dropping_next     = dropping;
    head_control_next = head_control;
    chain_length_next = chain_length;
    stored_count_next = stored_count;
    wr_en             = 1'b0;
    wr_addr           = base_cnt[AW-1:0];
    wr_data           = '{buf_id: in_data.buf_id, frag_len: in_data.frag_len};
    rd_en             = 1'b0;
    rd_addr           = '0;
    act_valid         = 1'b0;
    act               = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (dropping) begin
            if (!more) begin
              chain_open_next = 1'b0;
              dropping_next   = 1'b0;
            end
            state_next = S_REL_OWN;
          end else if (!chain_path) begin
            state_next = S_WRITE_OWN;
          end else begin
            wr_en = store;
            if (closing) begin
              chain_open_next   = 1'b0;
              head_control_next = '0;
              chain_length_next = '0;
              stored_count_next = '0;
              rd_en             = 1'b1;
              state_next        = S_SLOT_HEAD;
            end else if (overflow) begin
              chain_open_next   = 1'b1;
              dropping_next     = 1'b1;
              head_control_next = '0;
              chain_length_next = '0;
              stored_count_next = '0;
              rd_en             = 1'b1;
              state_next        = S_SLOTS;
            end else begin
              chain_open_next   = 1'b1;
              head_control_next = head_sel;
              chain_length_next = len_sum;
              stored_count_next = cnt_new;
              state_next        = opening ? S_WRITE_OWN : S_IDLE;
            end
          end
        end
      end
      S_WRITE_OWN: begin
        act_valid       = 1'b1;
        act.action_kind = KIND_WRITE;
        act.target_buf  = rec.buf_id;
        act.control_out = rec.control_word;
        act.run_last    = !standalone;
        if (out_free) begin
          state_next = standalone ? S_DISP_OWN : S_IDLE;
        end
      end
      S_DISP_OWN: begin
        act_valid          = 1'b1;
        act.action_kind    = KIND_DISPATCH;
        act.target_buf     = rec.buf_id;
        act.packet_total   = TOT_W'(rec.frag_len);
        act.piece_len      = rec.frag_len;
        act.dispatch_flags = FLAG_FINAL;
        act.run_last       = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_REL_OWN: begin
        act_valid       = 1'b1;
        act.action_kind = KIND_RELEASE;
        act.target_buf  = rec.buf_id;
        act.run_last    = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SLOT_HEAD: begin
        act_valid       = 1'b1;
        act.action_kind = KIND_WRITE;
        act.target_buf  = rd_data.buf_id;
        act.control_out = run_ctl;
        if (out_free) begin
          state_next = S_SLOTS;
        end
      end
      S_SLOTS: begin
        act_valid      = 1'b1;
        act.target_buf = rd_data.buf_id;
        act.run_last   = last_slot;
        if (run_release) begin
          act.action_kind = KIND_RELEASE;
        end else begin
          act.action_kind    = KIND_DISPATCH;
          act.packet_total   = run_total;
          act.piece_len      = rd_data.frag_len;
          act.dispatch_flags = slot_flags;
        end
        if (out_free) begin
          if (last_slot) begin
            state_next = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ord[AW-1:0];
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      chain_open   <= 1'b0;
      dropping     <= 1'b0;
      head_control <= '0;
      chain_length <= '0;
      stored_count <= '0;
    end else begin
      state        <= state_next;
      chain_open   <= chain_open_next;
      dropping     <= dropping_next;
      head_control <= head_control_next;
      chain_length <= chain_length_next;
      stored_count <= stored_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rec         <= in_data;
      standalone  <= !dropping && !chain_path;
      run_release <= overflow;
      run_cnt     <= cnt_new;
      run_total   <= len_sum[TOT_W-1:0];
      run_ctl     <= (head_sel & KEEP_MASK)
                     | (CTL_W'(len_sum[LEN_W-1:0]) << SHIFT_TOTAL);
      idx         <= '0;
    end else if (state == S_SLOTS && act_fire && !last_slot) begin
      idx <= ord[AW-1:0];
    end
  end

  `RFCA_ASSERT_NOW(a_no_rw_clash, clk, rst, wr_en && rd_en, wr_addr != rd_addr)
  `RFCA_ASSERT_NOW(a_drop_in_chain, clk, rst, dropping, chain_open)
  `RFCA_ASSERT_NOW(a_idle_empty, clk, rst, !chain_open, stored_count == '0)
  `RFCA_ASSERT_NEXT(a_run_ends_idle, clk, rst, act_fire && act.run_last, in_ready)

endmodule

`default_nettype wire

### hdl/rx_fragment_chain_assembler.sv
// Channel | Direction | Handshake          | Item
// in      | input     | in_valid/in_ready   | in_item_t: control word, buffer id, length
// out     | output    | out_valid/out_ready | out_item_t: one action per item
//
// A record is taken only while the sequencer is idle, and no new record is
// taken until every action it causes has been issued; a closing record
// causes up to MAX_PENDING + 2 actions.
// The slot memory read port delivers one stored fragment per cycle unless out stalls.
// Reset clears the chain state at once; the slot memory is not cleared.
// A stall on out holds the run in place; the output register frees the
// sequencer whenever the held item is taken.

`default_nettype none

module rx_fragment_chain_assembler
  import rfca_pkg::*;
#(
  parameter int MAX_PENDING = MAX_PENDING_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int SLOTS = MAX_PENDING + 1;
  localparam int AW    = $clog2(SLOTS);

  logic          out_free;
  logic          act_valid;
  out_item_t     act;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  slot_t         wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  slot_t         rd_data;

  assign out_free = !out_valid || out_ready;

  rfca_ctrl #(
    .MAX_PENDING(MAX_PENDING)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_free (out_free),
    .act_valid(act_valid),
    .act      (act),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  rfca_slot_mem #(
    .DEPTH(SLOTS)
  ) u_slot_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (act_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act_valid && out_free) begin
      out_data <= act;
    end
  end

endmodule

`default_nettype wire

### verif/rx_fragment_chain_assembler_tb.sv
module rx_fragment_chain_assembler_tb;
  import rfca_pkg::*;

  localparam int SLOT_COUNT = MAX_PENDING_DEF + 1;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 30;
  localparam int RECORD_TARGET = 380;

  class chain_action_board;
    out_item_t expected_actions[$];
    int mismatches = 0;
    bit chain_open = 1'b0;
    bit dropping = 1'b0;
    logic [CTL_W-1:0] head_control = '0;
    logic [CHAIN_W-1:0] chain_length = '0;
    int stored_count = 0;
    logic [BUF_W-1:0] slot_buf[SLOT_COUNT];
    logic [LEN_W-1:0] slot_len[SLOT_COUNT];

    function void clear_chain();
      head_control = '0;
      chain_length = '0;
      stored_count = 0;
      chain_open = 1'b0;
      dropping = 1'b0;
    endfunction

    function void queue_action(logic [1:0] kind, logic [BUF_W-1:0] bid,
                               logic [CTL_W-1:0] ctl, logic [TOT_W-1:0] total,
                               logic [LEN_W-1:0] len, logic [FLAG_W-1:0] flags);
      out_item_t act;
      act.action_kind = kind;
      act.target_buf = bid;
      act.control_out = ctl;
      act.packet_total = total;
      act.piece_len = len;
      act.dispatch_flags = flags;
      act.run_last = 1'b0;
      expected_actions.push_back(act);
    endfunction

    function logic [FLAG_W-1:0] fragment_flags(int count, int idx);
      int f;
      f = (count << SHIFT_COUNT) | ((idx + 1) << SHIFT_ORDINAL);
      if (idx + 1 == count) f = f | int'(FLAG_FINAL);
      return f[FLAG_W-1:0] & FLAGS_MASK;
    endfunction

    function void note_record(in_item_t rec);
      bit more;
      int first;
      int i;
      logic [CTL_W-1:0] rewritten;
      out_item_t tail;
      more = rec.control_word[0];
      first = expected_actions.size();
      if (dropping) begin
        queue_action(KIND_RELEASE, rec.buf_id, '0, '0, '0, '0);
        if (!more) clear_chain();
      end else if (!chain_open && !more) begin
        queue_action(KIND_WRITE, rec.buf_id, rec.control_word, '0, '0, '0);
        queue_action(KIND_DISPATCH, rec.buf_id, '0, TOT_W'(rec.frag_len), rec.frag_len,
                     FLAG_FINAL);
      end else begin
        if (!chain_open) begin
          chain_open = 1'b1;
          head_control = rec.control_word;
          chain_length = '0;
          stored_count = 0;
          queue_action(KIND_WRITE, rec.buf_id, rec.control_word, '0, '0, '0);
        end
        if (stored_count < SLOT_COUNT) begin
          slot_buf[stored_count] = rec.buf_id;
          slot_len[stored_count] = rec.frag_len;
          stored_count++;
        end
        chain_length = chain_length + CHAIN_W'(rec.frag_len);
        if (!more) begin
          rewritten = (head_control & KEEP_MASK) |
                      (CTL_W'(chain_length[LEN_W-1:0]) << SHIFT_TOTAL);
          queue_action(KIND_WRITE, slot_buf[0], rewritten, '0, '0, '0);
          for (i = 0; i < stored_count; i++)
            queue_action(KIND_DISPATCH, slot_buf[i], '0, chain_length[TOT_W-1:0],
                         slot_len[i], fragment_flags(stored_count, i));
          clear_chain();
        end else if (stored_count > MAX_PENDING_DEF) begin
          for (i = 0; i < stored_count; i++)
            queue_action(KIND_RELEASE, slot_buf[i], '0, '0, '0, '0);
          head_control = '0;
          chain_length = '0;
          stored_count = 0;
          dropping = 1'b1;
        end
      end
      if (expected_actions.size() > first) begin
        tail = expected_actions.pop_back();
        tail.run_last = 1'b1;
        expected_actions.push_back(tail);
      end
    endfunction

    function void report(string what, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: expected kind %0d buf %h ctl %h total %h len %h flags %h last %b",
                 what, want.action_kind, want.target_buf, want.control_out,
                 want.packet_total, want.piece_len, want.dispatch_flags, want.run_last);
        $display("%s:      got kind %0d buf %h ctl %h total %h len %h flags %h last %b",
                 what, got.action_kind, got.target_buf, got.control_out,
                 got.packet_total, got.piece_len, got.dispatch_flags, got.run_last);
      end
    endfunction

    function void check_action(out_item_t got);
      out_item_t want;
      if (expected_actions.size() == 0) begin
        report("unexpected action", '0, got);
      end else begin
        want = expected_actions.pop_front();
        if (got.action_kind !== want.action_kind || got.target_buf !== want.target_buf ||
            got.control_out !== want.control_out ||
            got.packet_total !== want.packet_total ||
            got.piece_len !== want.piece_len ||
            got.dispatch_flags !== want.dispatch_flags || got.run_last !== want.run_last)
          report("action mismatch", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  chain_action_board board = new();
  int idle_cycles = 0;
  int burst_left = 0;
  int records_sent = 0;
  int ready_mode = 0;
  int ready_hold = 0;

  rx_fragment_chain_assembler uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) board.note_record(in_data);
    if (!rst && out_valid && out_ready) board.check_action(out_data);
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("rx_fragment_chain_assembler_tb: FAIL");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_hold = $urandom_range(16, 96);
    end
    ready_hold--;
    case (ready_mode)
      0: out_ready = 1'b1;
      1: out_ready = 1'($urandom_range(0, 1));
      2: out_ready = ($urandom_range(0, 3) == 0);
      default: out_ready = ready_hold[1];
    endcase
  end

  function logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return LEN_W'($urandom_range(0, 15));
    if (r < 30) return LEN_W'(16383 - $urandom_range(0, 15));
    return LEN_W'($urandom_range(0, 16383));
  endfunction

  function in_item_t make_record(bit more, logic [LEN_W-1:0] len);
    in_item_t rec;
    rec.control_word = $urandom;
    rec.control_word[0] = more;
    rec.buf_id = BUF_W'($urandom);
    rec.frag_len = len;
    return rec;
  endfunction

  task send_record(input in_item_t rec);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) :
                                                 $urandom_range(1, 10);
    end
    in_valid = 1'b1;
    in_data = rec;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    records_sent++;
  endtask

  task send_chain(input int continuations, input bit longest);
    int i;
    for (i = 0; i < continuations; i++)
      send_record(make_record(1'b1, longest ? LEN_W'(16383) : pick_length()));
    send_record(make_record(1'b0, longest ? LEN_W'(16383) : pick_length()));
  endtask

  task wait_for_drain();
    in_valid = 1'b0;
    while (board.expected_actions.size() != 0) @(negedge clk);
  endtask

  initial begin
    int r;
    bit drained;
    drained = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_record('{control_word: 32'hffff_fffe, buf_id: 16'hffff, frag_len: 14'h3fff});
    send_record('{control_word: 32'h0, buf_id: 16'h0, frag_len: 14'h0});
    send_record('{control_word: 32'hffff_ffff, buf_id: 16'h0001, frag_len: 14'h3fff});
    send_record('{control_word: 32'h0, buf_id: 16'hfffe, frag_len: 14'h3fff});
    send_chain(MAX_PENDING_DEF, 1'b1);
    send_chain(MAX_PENDING_DEF + 3, 1'b0);
    wait_for_drain();

    while (records_sent < RECORD_TARGET) begin
      if (!drained && records_sent >= RECORD_TARGET / 2) begin
        wait_for_drain();
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_chain(0, 1'b0);
      end else if (r < 75) begin
        send_chain($urandom_range(1, MAX_PENDING_DEF), 1'b0);
      end else if (r < 87) begin
        send_chain(MAX_PENDING_DEF + 1 + $urandom_range(0, 3), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) send_record(make_record(1'($urandom_range(0, 1)),
                                                             pick_length()));
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (board.mismatches == 0 && board.expected_actions.size() == 0) begin
      $display("rx_fragment_chain_assembler_tb: PASS");
    end else begin
      $display("rx_fragment_chain_assembler_tb: FAIL");
    end
    $finish;
  end

endmodule
